[src/mi3_pkg.sv]
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EL_W      = 32;
  localparam int PROD_W    = 2 * EL_W;
  localparam int COF_W     = PROD_W + 1;
  localparam int CMAG_W    = PROD_W;
  localparam int DET_W     = COF_W + EL_W;
  localparam int DMAG_W    = DET_W - 1;
  localparam int NUM_W     = CMAG_W + 2 * FRAC_BITS;
  // quotient bits kept: 32 result bits plus one for the saturation check
  localparam int QB        = EL_W + 1;
  localparam int NHI_W     = NUM_W - QB;
  localparam int CMP_W     = (NHI_W > DMAG_W) ? NHI_W : DMAG_W;
  localparam int COF_LAT   = 2;
  localparam int DET_LAT   = 3;
  localparam int DIV_LAT   = QB + 3;
  localparam int PIPE_LAT  = COF_LAT + DET_LAT + DIV_LAT;

  typedef logic signed [EL_W-1:0]  el_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    el_t m00;
    el_t m01;
    el_t m02;
    el_t m10;
    el_t m11;
    el_t m12;
    el_t m20;
    el_t m21;
    el_t m22;
  } in_t;

  typedef struct packed {
    el_t  r00;
    el_t  r01;
    el_t  r02;
    el_t  r10;
    el_t  r11;
    el_t  r12;
    el_t  r20;
    el_t  r21;
    el_t  r22;
    logic singular;
    logic overflow;
  } out_t;

endpackage

[src/matrix3_inverse_core.sv]
// 3x3 matrix inverse, signed Q16.16 in and out.
// Input channel: in_valid_i / in_stall_o carry one matrix request (in_i,
// nine elements row by row). Output channel: out_valid_o / out_stall_i
// carry the inverse (out_o) with singular and overflow flags.
// A request is taken at a clock edge with valid high and stall low.
// Throughput: one matrix per cycle while in_stall_o is low. The pipeline
// forms products and cofactors, then the determinant, then runs a radix-2
// divider per element with one quotient bit per stage.
// Nine dividers run side by side, one per adjugate entry.
// A zero determinant gives singular = 1 and a zero matrix; a quotient
// outside 32 bits saturates and raises overflow.
// Reset clears all valid bits and the output buffer; no setup afterwards.
// When the receiver stalls, a two-entry output buffer absorbs one more
// result, then in_stall_o rises and the whole pipeline holds.
module matrix3_inverse_core import mi3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic          en;
  logic          skid_full;
  logic [PIPE_LAT-1:0] vld_q;

  cof_t cof_a [9];
  el_t  e_a [3];
  cof_t cof_b [9];
  det_t det;
  el_t  res [9];
  logic [8:0] ovf_v;
  logic [8:0] sing_v;
  out_t tail;

  assign en         = !skid_full;
  assign in_stall_o = skid_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  mi3_cof u_cof (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   (in_i),
    .cof_o (cof_a),
    .e_o   (e_a)
  );

  mi3_det u_det (
    .clk_i (clk_i),
    .en_i  (en),
    .cof_i (cof_a),
    .e_i   (e_a),
    .cof_o (cof_b),
    .det_o (det)
  );

  for (genvar k = 0; k < 9; k++) begin : g_div
    mi3_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .cof_i  (cof_b[k]),
      .det_i  (det),
      .res_o  (res[k]),
      .ovf_o  (ovf_v[k]),
      .sing_o (sing_v[k])
    );
  end

  always_comb begin
    tail.r00      = res[0];
    tail.r01      = res[1];
    tail.r02      = res[2];
    tail.r10      = res[3];
    tail.r11      = res[4];
    tail.r12      = res[5];
    tail.r20      = res[6];
    tail.r21      = res[7];
    tail.r22      = res[8];
    tail.singular = &sing_v;
    tail.overflow = |ovf_v;
  end

  mi3_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (vld_q[PIPE_LAT-1]),
    .up_data_i    (tail),
    .up_stall_o   (skid_full),
    .down_valid_o (out_valid_o),
    .down_data_o  (out_o),
    .down_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.singular |-> !out_o.overflow && out_o.r00 == '0
      && out_o.r11 == '0 && out_o.r22 == '0)
    else $error("singular result not cleared");

  a_skid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry held while output empty");

  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

[src/mi3_cof.sv]
module mi3_cof import mi3_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  in_t  m_i,
  output cof_t cof_o [9],
  output el_t  e_o [3]
);

  el_t a [9];
  el_t b [9];
  el_t c [9];
  el_t d [9];

  logic signed [PROD_W-1:0] pa_q [9];
  logic signed [PROD_W-1:0] pb_q [9];
  cof_t cof_q [9];
  el_t  e1_q [3];
  el_t  e2_q [3];

  always_comb begin
    a[0] = m_i.m11; b[0] = m_i.m22; c[0] = m_i.m21; d[0] = m_i.m12;
    a[1] = m_i.m02; b[1] = m_i.m21; c[1] = m_i.m01; d[1] = m_i.m22;
    a[2] = m_i.m01; b[2] = m_i.m12; c[2] = m_i.m02; d[2] = m_i.m11;
    a[3] = m_i.m12; b[3] = m_i.m20; c[3] = m_i.m10; d[3] = m_i.m22;
    a[4] = m_i.m00; b[4] = m_i.m22; c[4] = m_i.m02; d[4] = m_i.m20;
    a[5] = m_i.m10; b[5] = m_i.m02; c[5] = m_i.m00; d[5] = m_i.m12;
    a[6] = m_i.m10; b[6] = m_i.m21; c[6] = m_i.m20; d[6] = m_i.m11;
    a[7] = m_i.m20; b[7] = m_i.m01; c[7] = m_i.m00; d[7] = m_i.m21;
    a[8] = m_i.m00; b[8] = m_i.m11; c[8] = m_i.m10; d[8] = m_i.m01;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k]  <= a[k] * b[k];
        pb_q[k]  <= c[k] * d[k];
        cof_q[k] <= {pa_q[k][PROD_W-1], pa_q[k]} - {pb_q[k][PROD_W-1], pb_q[k]};
      end
      e1_q[0] <= m_i.m00;
      e1_q[1] <= m_i.m01;
      e1_q[2] <= m_i.m02;
      e2_q    <= e1_q;
    end
  end

  assign cof_o = cof_q;
  assign e_o   = e2_q;

endmodule

[src/mi3_det.sv]
module mi3_det import mi3_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  cof_t cof_i [9],
  input  el_t  e_i [3],
  output cof_t cof_o [9],
  output det_t det_o
);

  logic signed [EL_W:0]  hi [3];
  logic signed [EL_W:0]  lo [3];
  logic signed [COF_W-1:0] phi_q [3];
  logic signed [COF_W-1:0] plo_q [3];
  det_t t_q [3];
  det_t det_q;
  cof_t cd_q [3][9];

  // first-row expansion: c0*m00 + c3*m01 + c6*m02, cofactor split at bit 32
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hi[j] = $signed(cof_i[3*j][COF_W-1:EL_W]);
      lo[j] = $signed({1'b0, cof_i[3*j][EL_W-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        phi_q[j] <= hi[j] * e_i[j];
        plo_q[j] <= lo[j] * e_i[j];
        t_q[j]   <= {phi_q[j], {EL_W{1'b0}}}
                    + {{EL_W{plo_q[j][COF_W-1]}}, plo_q[j]};
      end
      det_q <= t_q[0] + t_q[1] + t_q[2];
      cd_q[0] <= cof_i;
      cd_q[1] <= cd_q[0];
      cd_q[2] <= cd_q[1];
    end
  end

  assign cof_o = cd_q[2];
  assign det_o = det_q;

endmodule

[src/mi3_div.sv]
module mi3_div import mi3_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  cof_t cof_i,
  input  det_t det_i,
  output el_t  res_o,
  output logic ovf_o,
  output logic sing_o
);

  logic [CMAG_W-1:0] cmag_q;
  logic [DMAG_W-1:0] dmag_q;
  logic              neg0_q;
  logic              sing0_q;

  logic [NUM_W-1:0]  num;
  logic [NHI_W-1:0]  nhi;

  logic [DMAG_W-1:0] rem_q  [QB+1];
  logic [DMAG_W-1:0] d_q    [QB+1];
  logic [QB-1:0]     nlo_q  [QB+1];
  logic [QB-1:0]     quo_q  [QB+1];
  logic              neg_q  [QB+1];
  logic              big_q  [QB+1];
  logic              sing_q [QB+1];

  logic [QB-1:0]     lim;
  logic              sat;
  logic [QB-1:0]     qsel;
  logic [EL_W-1:0]   mag;
  el_t               res_q;
  logic              ovf_q;
  logic              singo_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmag_q  <= cof_i[COF_W-1] ? CMAG_W'(-cof_i) : CMAG_W'(cof_i);
      dmag_q  <= det_i[DET_W-1] ? DMAG_W'(-det_i) : DMAG_W'(det_i);
      neg0_q  <= cof_i[COF_W-1] ^ det_i[DET_W-1];
      sing0_q <= (det_i == '0);
    end
  end

  // numerator is |c| << 2F; top part against the divisor tells quotient >= 2^QB
  always_comb begin
    num = {cmag_q, {(2 * FRAC_BITS){1'b0}}};
    nhi = num[NUM_W-1:QB];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DMAG_W'(nhi);
      d_q[0]    <= dmag_q;
      nlo_q[0]  <= num[QB-1:0];
      quo_q[0]  <= '0;
      neg_q[0]  <= neg0_q;
      big_q[0]  <= CMP_W'(nhi) >= CMP_W'(dmag_q);
      sing_q[0] <= sing0_q;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [DMAG_W:0] sh;
    logic            ge;

    always_comb begin
      sh = {rem_q[s], nlo_q[s][QB-1]};
      ge = sh >= {1'b0, d_q[s]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? DMAG_W'(sh - {1'b0, d_q[s]}) : sh[DMAG_W-1:0];
        d_q[s+1]    <= d_q[s];
        nlo_q[s+1]  <= nlo_q[s] << 1;
        quo_q[s+1]  <= {quo_q[s][QB-2:0], ge};
        neg_q[s+1]  <= neg_q[s];
        big_q[s+1]  <= big_q[s];
        sing_q[s+1] <= sing_q[s];
      end
    end
  end

  always_comb begin
    lim  = neg_q[QB] ? (QB'(1) << (EL_W - 1)) : ((QB'(1) << (EL_W - 1)) - QB'(1));
    sat  = big_q[QB] || (quo_q[QB] > lim);
    qsel = sat ? lim : quo_q[QB];
    mag  = qsel[EL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      singo_q <= sing_q[QB];
      if (sing_q[QB]) begin
        res_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        res_q <= neg_q[QB] ? el_t'(-mag) : el_t'(mag);
        ovf_q <= sat;
      end
    end
  end

  assign res_o  = res_q;
  assign ovf_o  = ovf_q;
  assign sing_o = singo_q;

endmodule

[src/mi3_skid.sv]
module mi3_skid import mi3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic up_valid_i,
  input  out_t up_data_i,
  output logic up_stall_o,
  output logic down_valid_o,
  output out_t down_data_o,
  input  logic down_stall_i
);

  logic ov_q;
  logic sv_q;
  out_t od_q;
  out_t sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (ov_q && down_stall_i) begin
      if (up_valid_i && !sv_q) begin
        sv_q <= 1'b1;
      end
    end else if (sv_q) begin
      sv_q <= 1'b0;
      ov_q <= 1'b1;
    end else begin
      ov_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && down_stall_i) begin
      if (up_valid_i && !sv_q) begin
        sd_q <= up_data_i;
      end
    end else if (sv_q) begin
      od_q <= sd_q;
    end else if (up_valid_i) begin
      od_q <= up_data_i;
    end
  end

  assign up_stall_o   = sv_q;
  assign down_valid_o = ov_q;
  assign down_data_o  = od_q;

endmodule

[verif/inverse_checker.sv]
module inverse_checker import mi3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_i,
  output int   fails_o,
  output int   pending_o
);

  typedef logic signed [159:0] wide_t;

  out_t pending_inverses[$];
  int   fails = 0;

  assign fails_o   = fails;
  assign pending_o = pending_inverses.size();

  // exact cofactors and determinant, single truncating division per element
  function automatic out_t inverse_of(in_t m);
    wide_t c[9];
    wide_t det, q;
    wide_t lo, hi;
    el_t   r[9];
    out_t  res;
    logic  ovf;
    lo  = -(wide_t'(1) <<< 31);
    hi  = (wide_t'(1) <<< 31) - 1;
    ovf = 1'b0;
    c[0] = wide_t'(m.m11) * wide_t'(m.m22) - wide_t'(m.m21) * wide_t'(m.m12);
    c[1] = wide_t'(m.m02) * wide_t'(m.m21) - wide_t'(m.m01) * wide_t'(m.m22);
    c[2] = wide_t'(m.m01) * wide_t'(m.m12) - wide_t'(m.m02) * wide_t'(m.m11);
    c[3] = wide_t'(m.m12) * wide_t'(m.m20) - wide_t'(m.m10) * wide_t'(m.m22);
    c[4] = wide_t'(m.m00) * wide_t'(m.m22) - wide_t'(m.m02) * wide_t'(m.m20);
    c[5] = wide_t'(m.m10) * wide_t'(m.m02) - wide_t'(m.m00) * wide_t'(m.m12);
    c[6] = wide_t'(m.m10) * wide_t'(m.m21) - wide_t'(m.m20) * wide_t'(m.m11);
    c[7] = wide_t'(m.m20) * wide_t'(m.m01) - wide_t'(m.m00) * wide_t'(m.m21);
    c[8] = wide_t'(m.m00) * wide_t'(m.m11) - wide_t'(m.m10) * wide_t'(m.m01);
    det = wide_t'(m.m00) * c[0] + wide_t'(m.m01) * c[3] + wide_t'(m.m02) * c[6];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      q = (c[k] <<< (2 * FRAC_BITS)) / det;
      if (q > hi) begin
        q = hi;
        ovf = 1'b1;
      end else if (q < lo) begin
        q = lo;
        ovf = 1'b1;
      end
      r[k] = el_t'(q);
    end
    res.r00 = r[0]; res.r01 = r[1]; res.r02 = r[2];
    res.r10 = r[3]; res.r11 = r[4]; res.r12 = r[5];
    res.r20 = r[6]; res.r21 = r[7]; res.r22 = r[8];
    res.overflow = ovf;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && in_valid_i && !in_stall_i)
      pending_inverses.push_back(inverse_of(in_i));
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (pending_inverses.size() == 0) begin
        report("unrequested result", 32'(out_i.singular), 32'(0));
      end else begin
        want = pending_inverses.pop_front();
        if (out_i.r00 != want.r00) report("r00", out_i.r00, want.r00);
        if (out_i.r01 != want.r01) report("r01", out_i.r01, want.r01);
        if (out_i.r02 != want.r02) report("r02", out_i.r02, want.r02);
        if (out_i.r10 != want.r10) report("r10", out_i.r10, want.r10);
        if (out_i.r11 != want.r11) report("r11", out_i.r11, want.r11);
        if (out_i.r12 != want.r12) report("r12", out_i.r12, want.r12);
        if (out_i.r20 != want.r20) report("r20", out_i.r20, want.r20);
        if (out_i.r21 != want.r21) report("r21", out_i.r21, want.r21);
        if (out_i.r22 != want.r22) report("r22", out_i.r22, want.r22);
        if (out_i.singular != want.singular)
          report("singular", 32'(out_i.singular), 32'(want.singular));
        if (out_i.overflow != want.overflow)
          report("overflow", 32'(out_i.overflow), 32'(want.overflow));
      end
    end
  end

endmodule

[verif/tb_top.sv]
module tb_top import mi3_pkg::*; ();

  localparam el_t ONE  = 32'sh0001_0000;
  localparam el_t EMAX = 32'sh7fff_ffff;
  localparam el_t EMIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fails, pending;
  int   sent = 0;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;
  int   quiet_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix3_inverse_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_data)
  );

  inverse_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_i(out_data),
    .fails_o(fails), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, quiet stretches, and one long hold on request
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_cnt == 1) begin
      hold_cnt <= -1;
      out_stall <= 1'b0;
    end else begin
      quiet_cnt <= (quiet_cnt + 1) % 600;
      if (quiet_cnt < 150) out_stall <= 1'b0;
      else if (out_stall) out_stall <= ($urandom_range(0, 99) < 70);
      else out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  task automatic send(in_t m);
    int g;
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk iff !in_stall);
    sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic el_t pick_el(int kind);
    int r;
    case (kind)
      0: return el_t'($urandom());
      1: return el_t'($signed($urandom_range(0, 524288)) - 262144);
      default: begin
        r = $urandom_range(0, 6);
        case (r)
          0: return '0;
          1: return ONE;
          2: return -ONE;
          3: return EMAX;
          4: return EMIN;
          5: return el_t'($urandom_range(1, 4));
          default: return el_t'($urandom());
        endcase
      end
    endcase
  endfunction

  function automatic in_t random_matrix();
    in_t m;
    int  kind, r;
    r = $urandom_range(0, 99);
    kind = (r < 35) ? 0 : (r < 80) ? 1 : 2;
    m.m00 = pick_el(kind); m.m01 = pick_el(kind); m.m02 = pick_el(kind);
    m.m10 = pick_el(kind); m.m11 = pick_el(kind); m.m12 = pick_el(kind);
    m.m20 = pick_el(kind); m.m21 = pick_el(kind); m.m22 = pick_el(kind);
    if (kind == 1 && $urandom_range(0, 1)) begin
      // diagonal pushed out by 4.0, toward a well-conditioned inverse
      m.m00 = m.m00 + 4 * ONE;
      m.m11 = m.m11 - 4 * ONE;
      m.m22 = m.m22 + 4 * ONE;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
    end else if (r < 12) begin
      m.m01 = '0; m.m11 = '0; m.m21 = '0;
    end
    return m;
  endfunction

  function automatic in_t diag(el_t a, el_t b, el_t c);
    in_t m;
    m = '0;
    m.m00 = a; m.m11 = b; m.m22 = c;
    return m;
  endfunction

  initial begin
    in_t m;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(diag(ONE, ONE, ONE));
    send('0);
    send(diag(2 * ONE, -4 * ONE, ONE / 2));
    send(diag(EMAX, EMAX, EMAX));
    send(diag(EMIN, EMIN, EMIN));
    send(diag(32'sd1, 32'sd1, 32'sd1));          // tiny det: saturates
    send(diag(32'sd1, -32'sd1, 32'sd1));
    send(diag(ONE, ONE, 32'sd0));                // singular
    m = '1; send(m);                             // all -1 LSB, singular
    m = {9{EMAX}}; send(m);
    m = {9{EMIN}}; send(m);
    m = {EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMAX, EMIN, EMIN}; send(m);
    m = {EMAX, 32'sd0, 32'sd0, 32'sd0, EMIN, 32'sd0, 32'sd0, 32'sd0, EMAX}; send(m);
    m = {ONE, 2 * ONE, 3 * ONE, 32'sd0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 32'sd0};
    send(m);
    m = {32'sd0, ONE, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -ONE}; send(m);
    m = {ONE, ONE, ONE, ONE, ONE + 1, ONE, ONE, ONE, ONE + 1}; send(m);
    m = {3 * ONE, -ONE, 32'sd7, 32'sd5, 2 * ONE, -32'sd9, -ONE, 32'sd11, 6 * ONE};
    send(m);

    for (int i = 0; i < 1800; i++) begin
      if (i == 300) hold_req <= 1'b1;
      send(random_matrix());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
